[rtl/c_string_escape_decoder_core_assert.svh]
// assertion macros shared by the string escape decoder modules
`ifndef C_STRING_ESCAPE_DECODER_CORE_ASSERT_SVH
`define C_STRING_ESCAPE_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define CSED_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csed assertion failed");

// next-cycle implication
`define CSED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csed assertion failed");

`endif

[rtl/csed_pkg.sv]
// types and constants of the string escape decoder
package csed_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_BODY   = 3'd1,
        MODE_BSL    = 3'd2,
        MODE_OCT    = 3'd3,
        MODE_HEX    = 3'd4,
        MODE_CLOSED = 3'd5,
        MODE_DRAIN  = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] esc;
        logic [1:0] dcnt;
        logic [1:0] dlim;
    } t_state;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_res;

    typedef struct packed {
        logic [1:0] n;
        t_res       r0;
        t_res       r1;
    } t_step_res;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LN    = 8'h6E;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [7:0] CH_LT    = 8'h74;
    localparam logic [7:0] CH_LV    = 8'h76;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam logic [7:0] ESC_BEL  = 8'd7;
    localparam logic [7:0] ESC_BS   = 8'd8;
    localparam logic [7:0] ESC_HT   = 8'd9;
    localparam logic [7:0] ESC_LF   = 8'd10;
    localparam logic [7:0] ESC_VT   = 8'd11;
    localparam logic [7:0] ESC_FF   = 8'd12;
    localparam logic [7:0] ESC_CR   = 8'd13;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

endpackage

[rtl/csed_step.sv]
// next state and results of the decoder for one input byte
module csed_step
    import csed_pkg::*;
(
    input  t_state     i_st,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_state     o_st,
    output t_step_res  o_res
);

    logic [1:0] dn;
    logic [7:0] dat0;
    logic [7:0] dat1;
    logic       err;
    logic       acc;
    logic       drain;
    logic       is_oct;
    logic       is_space;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic [7:0] hex_diff;
    logic [7:0] named;
    logic [7:0] oct_val;
    logic [1:0] dcnt_inc;
    t_state     nx;
    t_res       vr0;
    t_res       vr1;
    logic [1:0] vn;

    assign is_oct   = (i_byte >= CH_0) && (i_byte <= CH_7);
    assign is_space = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));
    assign oct_val  = {i_st.esc[4:0], i_byte[2:0]};
    assign dcnt_inc = i_st.dcnt + 2'd1;

    always_comb begin
        hex_ok   = 1'b1;
        hex_diff = i_byte - CH_0;
        if ((i_byte >= CH_0) && (i_byte <= CH_9)) begin
            hex_diff = i_byte - CH_0;
        end else if ((i_byte >= CH_LA) && (i_byte <= CH_LF)) begin
            hex_diff = i_byte - CH_LA + 8'd10;
        end else if ((i_byte >= CH_UA) && (i_byte <= CH_UF)) begin
            hex_diff = i_byte - CH_UA + 8'd10;
        end else begin
            hex_ok = 1'b0;
        end
        hex_val = hex_diff[3:0];
    end

    always_comb begin
        case (i_byte)
            CH_LA:   named = ESC_BEL;
            CH_LB:   named = ESC_BS;
            CH_LT:   named = ESC_HT;
            CH_LN:   named = ESC_LF;
            CH_LV:   named = ESC_VT;
            CH_LF:   named = ESC_FF;
            CH_LR:   named = ESC_CR;
            default: named = i_byte;
        endcase
    end

    always_comb begin
        nx    = i_st;
        dn    = 2'd0;
        dat0  = 8'd0;
        dat1  = 8'd0;
        err   = 1'b0;
        acc   = 1'b0;
        drain = 1'b0;
        case (i_st.mode)
            MODE_IDLE: begin
                if (i_byte == CH_QUOTE) begin
                    nx.mode = MODE_BODY;
                end else if (!is_space) begin
                    err = 1'b1;
                end
            end
            MODE_BODY: begin
                if (i_byte == CH_NUL) begin
                    err = 1'b1;
                end else if (i_byte == CH_QUOTE) begin
                    nx.mode = MODE_CLOSED;
                end else if (i_byte == CH_BSL) begin
                    nx.mode = MODE_BSL;
                end else begin
                    dn   = 2'd1;
                    dat0 = i_byte;
                end
            end
            MODE_BSL: begin
                if (i_byte == CH_NUL) begin
                    err = 1'b1;
                end else if (is_oct) begin
                    nx.esc  = {5'd0, i_byte[2:0]};
                    nx.dcnt = 2'd1;
                    nx.dlim = (i_byte <= CH_3) ? 2'd3 : 2'd2;
                    nx.mode = MODE_OCT;
                end else if ((i_byte == CH_LX) || (i_byte == CH_UX)) begin
                    nx.esc  = i_byte;
                    nx.dcnt = 2'd0;
                    nx.dlim = 2'd2;
                    nx.mode = MODE_HEX;
                end else begin
                    dn      = 2'd1;
                    dat0    = named;
                    nx.mode = MODE_BODY;
                end
            end
            MODE_OCT, MODE_HEX: begin
                if ((i_st.mode == MODE_OCT) && is_oct) begin
                    nx.esc  = oct_val;
                    nx.dcnt = dcnt_inc;
                    if (dcnt_inc >= i_st.dlim) begin
                        dn      = 2'd1;
                        dat0    = oct_val;
                        nx.mode = MODE_BODY;
                    end
                end else if ((i_st.mode == MODE_HEX) && hex_ok) begin
                    if (i_st.dcnt == 2'd0) begin
                        nx.esc  = {4'd0, hex_val};
                        nx.dcnt = 2'd1;
                    end else begin
                        dn      = 2'd1;
                        dat0    = {i_st.esc[3:0], hex_val};
                        nx.mode = MODE_BODY;
                    end
                end else begin
                    // pending escape, then the byte as a body byte
                    dn      = 2'd1;
                    dat0    = i_st.esc;
                    nx.mode = MODE_BODY;
                    if (i_byte == CH_NUL) begin
                        err = 1'b1;
                    end else if (i_byte == CH_QUOTE) begin
                        nx.mode = MODE_CLOSED;
                    end else if (i_byte == CH_BSL) begin
                        nx.mode = MODE_BSL;
                    end else begin
                        dn   = 2'd2;
                        dat1 = i_byte;
                    end
                end
            end
            MODE_CLOSED: begin
                if (i_byte == CH_NUL) begin
                    acc = 1'b1;
                end else begin
                    err = 1'b1;
                end
            end
            default: begin
                drain = 1'b1;
                if (i_last) begin
                    nx.mode = MODE_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_st = nx;
        vn   = dn;
        vr0  = '{data: dat0, kind: KIND_DATA, last: 1'b0};
        vr1  = '{data: dat1, kind: KIND_DATA, last: 1'b0};
        if (drain) begin
            vn = 2'd0;
        end else if (err || (i_last && !acc && (nx.mode != MODE_CLOSED))) begin
            vn  = 2'd1;
            vr0 = '{data: 8'd0, kind: KIND_ERROR, last: 1'b0};
        end else if (acc || i_last) begin
            // verdict after any data bytes
            case (dn)
                2'd0: begin
                    vn  = 2'd1;
                    vr0 = '{data: 8'd0, kind: KIND_ACCEPT, last: 1'b0};
                end
                2'd1: begin
                    vn  = 2'd2;
                    vr1 = '{data: 8'd0, kind: KIND_ACCEPT, last: 1'b0};
                end
                default: vn = 2'd2;
            endcase
        end
        if (!drain && (err || acc || i_last)) begin
            o_st.mode = i_last ? MODE_IDLE : MODE_DRAIN;
            o_st.esc  = 8'd0;
            o_st.dcnt = 2'd0;
            o_st.dlim = 2'd0;
        end
        vr0.last = (vn == 2'd1);
        vr1.last = 1'b1;
        o_res    = '{n: vn, r0: vr0, r1: vr1};
    end

endmodule

[rtl/csed_res_queue.sv]
// small result queue, up to two writes and one read per cycle
module csed_res_queue
    import csed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_n,
    input  t_res       i_r0,
    input  t_res       i_r1,
    output logic       o_room,
    output logic       o_valid,
    output t_res       o_head,
    input  logic       i_stall
);

    t_res                r_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] r_wp;
    logic [RQ_PTR_W-1:0] n_wp;
    logic [RQ_PTR_W-1:0] r_rp;
    logic [RQ_PTR_W-1:0] n_rp;
    logic [RQ_CNT_W-1:0] r_cnt;
    logic [RQ_CNT_W-1:0] n_cnt;
    logic [RQ_PTR_W-1:0] wp1;
    logic                pop;

    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign o_head  = r_mem[r_rp];
    assign pop     = o_valid && !i_stall;
    assign wp1     = r_wp + RQ_PTR_W'(1);
    assign n_wp    = r_wp + RQ_PTR_W'(i_push_n);
    assign n_rp    = r_rp + RQ_PTR_W'(pop);
    assign n_cnt   = r_cnt + RQ_CNT_W'(i_push_n) - RQ_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wp] <= i_r0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wp1] <= i_r1;
        end
    end

`include "c_string_escape_decoder_core_assert.svh"

    `CSED_ASSERT_NOW(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= RQ_CNT_W'(RQ_DEPTH))
    `CSED_ASSERT_NOW(a_push_room, i_clk, i_rst_n, i_push_n != 2'd0, o_room)
    `CSED_ASSERT_NOW(a_push_n, i_clk, i_rst_n, 1'b1, i_push_n != 2'd3)

endmodule

[rtl/c_string_escape_decoder_core.sv]
// top level of the C string literal escape decoder
// a transferred byte is registered, decoded into up to two results and queued for output
// throughput: one byte per cycle while the queue has room; results leave one per transfer
// the decode step sits between the input register and a four-entry result queue
// reset: synchronous active-low, returns to idle skipping whitespace, queue empty
module c_string_escape_decoder_core
    import csed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_out_kind,
    output logic       o_out_last
);

    logic       r_in_vld;
    logic       n_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_state     r_st;
    t_state     n_st;
    t_state     step_st;
    t_step_res  step_res;
    logic       room;
    logic       consume;
    logic       load;
    t_res       head;

    assign consume    = r_in_vld && room;
    assign o_in_stall = r_in_vld && !room;
    assign load       = i_in_valid && !o_in_stall;
    assign n_in_vld   = load || (r_in_vld && !consume);
    assign n_st       = consume ? step_st : r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_st     <= '{mode: MODE_IDLE, esc: 8'd0, dcnt: 2'd0, dlim: 2'd0};
        end else begin
            r_in_vld <= n_in_vld;
            r_st     <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    csed_step u_step (
        .i_st   (r_st),
        .i_byte (r_in_byte),
        .i_last (r_in_last),
        .o_st   (step_st),
        .o_res  (step_res)
    );

    csed_res_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (consume ? step_res.n : 2'd0),
        .i_r0     (step_res.r0),
        .i_r1     (step_res.r1),
        .o_room   (room),
        .o_valid  (o_out_valid),
        .o_head   (head),
        .i_stall  (i_out_stall)
    );

    assign o_out_byte = head.data;
    assign o_out_kind = head.kind;
    assign o_out_last = head.last;

`include "c_string_escape_decoder_core_assert.svh"

    `CSED_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, consume && r_in_last, r_st.mode == MODE_IDLE)
    `CSED_ASSERT_NEXT(a_err_ends, i_clk, i_rst_n,
        consume && (step_res.n != 2'd0) && (step_res.r0.kind == KIND_ERROR),
        (r_st.mode == MODE_IDLE) || (r_st.mode == MODE_DRAIN))
    `CSED_ASSERT_NOW(a_drain_quiet, i_clk, i_rst_n,
        consume && (r_st.mode == MODE_DRAIN), step_res.n == 2'd0)

endmodule

[test/c_string_escape_decoder_core_checker.sv]
// checker for the string escape decoder: predicts decoded results and compares each output transfer
module c_string_escape_decoder_core_checker
    import csed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic [1:0] i_out_kind,
    input  logic       i_out_last,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_mode      parse_mode;
    logic [7:0] esc_acc;
    logic [1:0] dig_cnt;
    logic [1:0] dig_lim;
    t_res       step_res[$];
    t_res       decoded_q[$];
    int         fails = 0;

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fails++;
    endtask

    function automatic void add_res(input t_kind k, input logic [7:0] b);
        t_res r;
        if (step_res.size() < 2) begin
            r.data = (k == KIND_DATA) ? b : 8'h00;
            r.kind = k;
            r.last = 1'b0;
            step_res.push_back(r);
        end
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        return -1;
    endfunction

    function automatic logic [7:0] named_code(input logic [7:0] c);
        case (c)
            CH_LA: return ESC_BEL;
            CH_LB: return ESC_BS;
            CH_LT: return ESC_HT;
            CH_LN: return ESC_LF;
            CH_LV: return ESC_VT;
            CH_LF: return ESC_FF;
            CH_LR: return ESC_CR;
            default: return c;
        endcase
    endfunction

    // one byte inside the quotes, returns 1 on a syntax error
    function automatic bit body_char(input logic [7:0] c);
        if (c == CH_NUL) return 1'b1;
        if (c == CH_QUOTE) parse_mode = MODE_CLOSED;
        else if (c == CH_BSL) parse_mode = MODE_BSL;
        else add_res(KIND_DATA, c);
        return 1'b0;
    endfunction

    function automatic void decode_literal_byte(input logic [7:0] c, input logic lst);
        bit   err;
        bit   acc;
        bit   quiet;
        int   h;
        t_res r;
        err = 1'b0;
        acc = 1'b0;
        quiet = 1'b0;
        step_res.delete();
        case (parse_mode)
            MODE_IDLE: begin
                if (c == CH_QUOTE) parse_mode = MODE_BODY;
                else if (!is_blank(c)) err = 1'b1;
            end
            MODE_BODY: begin
                err = body_char(c);
            end
            MODE_BSL: begin
                if (c == CH_NUL) begin
                    err = 1'b1;
                end else if (c >= CH_0 && c <= CH_7) begin
                    esc_acc = c - CH_0;
                    dig_cnt = 2'd1;
                    dig_lim = (c <= CH_3) ? 2'd3 : 2'd2;
                    parse_mode = MODE_OCT;
                end else if (c == CH_LX || c == CH_UX) begin
                    esc_acc = c;
                    dig_cnt = 2'd0;
                    dig_lim = 2'd2;
                    parse_mode = MODE_HEX;
                end else begin
                    add_res(KIND_DATA, named_code(c));
                    parse_mode = MODE_BODY;
                end
            end
            MODE_OCT: begin
                if (c >= CH_0 && c <= CH_7) begin
                    esc_acc = {esc_acc[4:0], c[2:0]};
                    dig_cnt = dig_cnt + 2'd1;
                    if (dig_cnt >= dig_lim) begin
                        add_res(KIND_DATA, esc_acc);
                        parse_mode = MODE_BODY;
                    end
                end else begin
                    add_res(KIND_DATA, esc_acc);
                    parse_mode = MODE_BODY;
                    err = body_char(c);
                end
            end
            MODE_HEX: begin
                h = hex_digit(c);
                if (h >= 0) begin
                    if (dig_cnt == 2'd0) begin
                        esc_acc = h[7:0];
                        dig_cnt = 2'd1;
                    end else begin
                        add_res(KIND_DATA, {esc_acc[3:0], h[3:0]});
                        parse_mode = MODE_BODY;
                    end
                end else begin
                    add_res(KIND_DATA, esc_acc);
                    parse_mode = MODE_BODY;
                    err = body_char(c);
                end
            end
            MODE_CLOSED: begin
                if (c == CH_NUL) acc = 1'b1;
                else err = 1'b1;
            end
            default: begin
                if (lst) parse_mode = MODE_IDLE;
                quiet = 1'b1;
            end
        endcase
        if (!quiet) begin
            if (err) begin
                step_res.delete();
                add_res(KIND_ERROR, 8'h00);
            end else if (acc) begin
                add_res(KIND_ACCEPT, 8'h00);
            end else if (lst) begin
                if (parse_mode == MODE_CLOSED) begin
                    add_res(KIND_ACCEPT, 8'h00);
                end else begin
                    step_res.delete();
                    add_res(KIND_ERROR, 8'h00);
                end
                acc = 1'b1;
            end
            if (err || acc) begin
                parse_mode = lst ? MODE_IDLE : MODE_DRAIN;
                esc_acc = 8'h00;
                dig_cnt = 2'd0;
                dig_lim = 2'd0;
            end
            foreach (step_res[k]) begin
                r = step_res[k];
                r.last = (k == step_res.size() - 1);
                decoded_q.push_back(r);
            end
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_res want;
        if (!i_rst_n) begin
            parse_mode = MODE_IDLE;
            esc_acc = 8'h00;
            dig_cnt = 2'd0;
            dig_lim = 2'd0;
            decoded_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) decode_literal_byte(i_in_byte, i_in_last);
            if (i_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    flag_mismatch($sformatf("result with none expected: byte %02h kind %0d last %0b",
                                            i_out_byte, i_out_kind, i_out_last));
                end else begin
                    want = decoded_q.pop_front();
                    if (i_out_kind !== want.kind)
                        flag_mismatch($sformatf("kind %0d, expected %0d", i_out_kind, want.kind));
                    if (i_out_byte !== want.data)
                        flag_mismatch($sformatf("byte %02h, expected %02h", i_out_byte, want.data));
                    if (i_out_last !== want.last)
                        flag_mismatch($sformatf("last %0b, expected %0b", i_out_last, want.last));
                end
            end
        end
        o_pending <= decoded_q.size();
        o_fail_count <= fails;
    end

endmodule

[test/tb_c_string_escape_decoder_core.sv]
// testbench top for the string escape decoder: clock, reset, literal stimulus and verdict
module tb_c_string_escape_decoder_core
    import csed_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 5000;
    localparam int PHASE_BYTES = 570;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       out_last;

    int         fail_count;
    int         pending;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    int         sent_cnt = 0;
    int         quiet_cycles = 0;
    logic [7:0] lit_q[$];

    c_string_escape_decoder_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_byte   (in_byte),
        .i_in_last   (in_last),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_byte  (out_byte),
        .o_out_kind  (out_kind),
        .o_out_last  (out_last)
    );

    c_string_escape_decoder_core_checker decode_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_byte    (in_byte),
        .i_in_last    (in_last),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_byte   (out_byte),
        .i_out_kind   (out_kind),
        .i_out_last   (out_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= IDLE_LIMIT) begin
                    $display("c_string_escape_decoder_core regression: fail");
                    $finish;
                end
            end
        end
    end

    task automatic xfer_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        in_last <= lst;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_cnt++;
    endtask

    task automatic send_text(input string s, input bit end_mark);
        for (int i = 0; i < s.len(); i++) xfer_byte(s[i], end_mark && (i == s.len() - 1));
    endtask

    task automatic send_literal();
        foreach (lit_q[i]) xfer_byte(lit_q[i], i == lit_q.size() - 1);
    endtask

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return CH_0 + 8'(v);
        return ($urandom_range(1) ? CH_LA : CH_UA) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] plain_char(input logic [7:0] b);
        return (b == CH_QUOTE || b == CH_BSL || b == CH_NUL) ? CH_UA : b;
    endfunction

    // well-formed literal with random escapes and a random ending
    task automatic make_literal();
        logic [7:0] letters[7];
        int         n;
        letters = '{CH_LA, CH_LB, CH_LT, CH_LN, CH_LV, CH_LF, CH_LR};
        lit_q.delete();
        repeat ($urandom_range(0, 2))
            lit_q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4)));
        lit_q.push_back(CH_QUOTE);
        repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 5))
                0: lit_q.push_back(plain_char(8'($urandom_range(1, 255))));
                1: begin
                    lit_q.push_back(CH_BSL);
                    lit_q.push_back(letters[$urandom_range(0, 6)]);
                end
                2: begin
                    lit_q.push_back(CH_BSL);
                    n = $urandom_range(1, 3);
                    repeat (n) lit_q.push_back(CH_0 + 8'($urandom_range(0, 7)));
                end
                3: begin
                    lit_q.push_back(CH_BSL);
                    lit_q.push_back($urandom_range(1) ? CH_LX : CH_UX);
                    n = $urandom_range(0, 2);
                    repeat (n) lit_q.push_back(hex_char($urandom_range(0, 15)));
                end
                4: begin
                    lit_q.push_back(CH_BSL);
                    lit_q.push_back(8'($urandom_range(1, 255)));
                end
                default: lit_q.push_back(plain_char(8'($urandom_range(32, 126))));
            endcase
        end
        lit_q.push_back(CH_QUOTE);
        if ($urandom_range(99) < 30) begin
            lit_q.push_back(CH_NUL);
            repeat ($urandom_range(0, 2)) lit_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // broken literal: truncated, corrupted or with an embedded zero
    task automatic break_literal();
        int n;
        case ($urandom_range(0, 2))
            0: begin
                n = $urandom_range(1, lit_q.size());
                while (lit_q.size() > n) void'(lit_q.pop_back());
            end
            1: lit_q[$urandom_range(0, lit_q.size() - 1)] = 8'($urandom_range(0, 255));
            default: lit_q.insert($urandom_range(0, lit_q.size() - 1), CH_NUL);
        endcase
    endtask

    initial begin : stim
        int pick;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 66 : 0;
            stall_pct = (ph == 0) ? 66 : (ph == 1) ? 8 : 0;
            if (ph == 0) begin
                send_text("\t \"\\xG\\1234\\Xa\"", 1'b1);
                xfer_byte(CH_QUOTE, 1'b0);
                xfer_byte(8'hFF, 1'b0);
                send_text("\\77\"", 1'b0);
                xfer_byte(CH_NUL, 1'b0);
                send_text("z", 1'b1);
                send_text("\"\\5", 1'b0);
                xfer_byte(CH_NUL, 1'b1);
                send_text("\"\\", 1'b1);
                send_text("q", 1'b0);
                send_text("\"", 1'b1);
            end
            while (sent_cnt < PHASE_BYTES * (ph + 1)) begin
                pick = $urandom_range(99);
                make_literal();
                if (pick >= 92) begin
                    lit_q.delete();
                    repeat ($urandom_range(1, 5)) lit_q.push_back(8'($urandom_range(0, 255)));
                end else if (pick >= 80) begin
                    break_literal();
                end
                send_literal();
            end
        end
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("c_string_escape_decoder_core regression: pass");
        end else begin
            $display("c_string_escape_decoder_core regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/csed_pkg.sv
rtl/csed_step.sv
rtl/csed_res_queue.sv
rtl/c_string_escape_decoder_core.sv
test/c_string_escape_decoder_core_checker.sv
test/tb_c_string_escape_decoder_core.sv
